// ===== sv/gthd_pkg.sv =====
`default_nettype none

package gthd_pkg;

    localparam int unsigned GY_MIN    = 2001;
    localparam int unsigned GY_MAX    = 2099;
    localparam int unsigned GY_BASE   = 2000;
    localparam int unsigned DAY_BASE  = 197;
    localparam int unsigned HIJRI_EPOCH = 1420;
    localparam int unsigned MONTH_LAST = 13;

    localparam logic [35:0] LUNAR_E6  = 36'd354367068;
    localparam logic [35:0] SCALE_E6  = 36'd1000000;
    localparam logic [25:0] LUNAR_FRAC_E6 = 26'd367068;
    localparam logic [25:0] FRAC_SCALE_E6 = 26'd1000000;
    localparam logic [15:0] LUNAR_INT = 16'd354;

    localparam logic [2:0] YEAR_BIT_TOP = 3'd6;
    localparam logic [2:0] FRAC_BIT_TOP = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCALE,
        ST_YEAR,
        ST_FRAC,
        ST_REM,
        ST_MONTH,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       scale;
        logic       year_step;
        logic       frac_step;
        logic       rem;
        logic       month;
        logic       out_load;
        logic [2:0] bit_idx;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // floor(30.6001 * (m + 1)) for the shifted month 3..14
    function automatic logic [8:0] greg_month_days(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd3:    d = 9'd122;
            4'd4:    d = 9'd153;
            4'd5:    d = 9'd183;
            4'd6:    d = 9'd214;
            4'd7:    d = 9'd244;
            4'd8:    d = 9'd275;
            4'd9:    d = 9'd306;
            4'd10:   d = 9'd336;
            4'd11:   d = 9'd367;
            4'd12:   d = 9'd397;
            4'd13:   d = 9'd428;
            4'd14:   d = 9'd459;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // floor(29.5 * m - 28.999), day offset of hijri month start
    function automatic logic [8:0] hijri_month_start(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd30;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd89;
            4'd5:    d = 9'd118;
            4'd6:    d = 9'd148;
            4'd7:    d = 9'd177;
            4'd8:    d = 9'd207;
            4'd9:    d = 9'd236;
            4'd10:   d = 9'd266;
            4'd11:   d = 9'd295;
            4'd12:   d = 9'd325;
            4'd13:   d = 9'd354;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gthd_ctrl.sv =====
`default_nettype none

module gthd_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire gthd_pkg::status_t status,
    output gthd_pkg::cmd_t        cmd
);

    gthd_pkg::state_t state_reg, state_next;
    logic [2:0]       cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gthd_pkg::ST_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            gthd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = gthd_pkg::ST_PREP;
                end
            end
            gthd_pkg::ST_PREP:
            begin
                state_next = gthd_pkg::ST_SCALE;
            end
            gthd_pkg::ST_SCALE:
            begin
                state_next = gthd_pkg::ST_YEAR;
                cnt_next   = gthd_pkg::YEAR_BIT_TOP;
            end
            gthd_pkg::ST_YEAR:
            begin
                if (cnt_reg == 3'd0)
                begin
                    state_next = gthd_pkg::ST_FRAC;
                    cnt_next   = gthd_pkg::FRAC_BIT_TOP;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            gthd_pkg::ST_FRAC:
            begin
                if (cnt_reg == 3'd0)
                begin
                    state_next = gthd_pkg::ST_REM;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            gthd_pkg::ST_REM:
            begin
                state_next = gthd_pkg::ST_MONTH;
            end
            gthd_pkg::ST_MONTH:
            begin
                state_next = gthd_pkg::ST_DONE;
            end
            gthd_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = gthd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gthd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.bit_idx = cnt_reg;
        s_tready    = 1'b0;
        unique case (state_reg)
            gthd_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            gthd_pkg::ST_PREP:  cmd.prep      = 1'b1;
            gthd_pkg::ST_SCALE: cmd.scale     = 1'b1;
            gthd_pkg::ST_YEAR:  cmd.year_step = 1'b1;
            gthd_pkg::ST_FRAC:  cmd.frac_step = 1'b1;
            gthd_pkg::ST_REM:   cmd.rem       = 1'b1;
            gthd_pkg::ST_MONTH: cmd.month     = 1'b1;
            gthd_pkg::ST_DONE:  cmd.out_load  = status.out_free;
            default:            cmd.load      = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/gthd_dp.sv =====
`default_nettype none

module gthd_dp (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_wen,
    input  wire logic [2:0]     cfg_wdata,
    input  wire logic [23:0]    s_tdata,
    output logic                m_tvalid,
    input  wire logic           m_tready,
    output logic [23:0]         m_tdata,
    input  wire gthd_pkg::cmd_t cmd,
    output gthd_pkg::status_t   status
);

    logic [2:0]  corr_reg;
    logic [11:0] gy_reg;
    logic [3:0]  gm_reg;
    logic [4:0]  gd_reg;
    logic [15:0] nday_reg, nday_next;
    logic [35:0] nscl_reg;
    logic [6:0]  k_reg, k_cand;
    logic [5:0]  q_reg, q_cand;
    logic [8:0]  rem_reg;
    logic [4:0]  day_reg, day_next;
    logic [3:0]  mon_reg, mon_next;
    logic [10:0] year_reg;
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    logic [11:0] gy_c;
    logic [3:0]  gm_c, m_adj;
    logic        early;
    logic [6:0]  yr7;
    logic        year_hit, frac_hit;
    logic [15:0] yp, rem_full;
    logic [8:0]  day_sub;
    logic [3:0]  mon_srch;

    // day count from the 2000-based epoch, jan/feb as months 13/14
    always_comb
    begin
        priority if (gy_reg < 12'(gthd_pkg::GY_MIN))
            gy_c = 12'(gthd_pkg::GY_MIN);
        else if (gy_reg > 12'(gthd_pkg::GY_MAX))
            gy_c = 12'(gthd_pkg::GY_MAX);
        else
            gy_c = gy_reg;
        priority if (gm_reg == 4'd0)
            gm_c = 4'd1;
        else if (gm_reg > 4'd12)
            gm_c = 4'd12;
        else
            gm_c = gm_reg;
        early     = gm_c < 4'd3;
        m_adj     = early ? gm_c + 4'd12 : gm_c;
        yr7       = 7'(gy_c - 12'(gthd_pkg::GY_BASE) - {11'd0, early});
        nday_next = 16'(yr7) * 16'd365 + 16'(yr7 >> 2)
                  + 16'(gthd_pkg::greg_month_days(m_adj)) + 16'(gd_reg)
                  + 16'(gthd_pkg::DAY_BASE) + {{13{corr_reg[2]}}, corr_reg};
    end

    // bit-serial search: k = last year whose start is not after nday,
    // q = floor(0.367068 * k)
    always_comb
    begin
        k_cand = k_reg;
        k_cand[cmd.bit_idx] = 1'b1;
        q_cand = q_reg;
        q_cand[cmd.bit_idx[2:0]] = 1'b1;
        year_hit = (gthd_pkg::LUNAR_E6 * 36'(k_cand)) < nscl_reg;
        frac_hit = (gthd_pkg::FRAC_SCALE_E6 * 26'(q_cand))
                <= (gthd_pkg::LUNAR_FRAC_E6 * 26'(k_reg));
        yp       = gthd_pkg::LUNAR_INT * 16'(k_reg) + 16'(q_reg);
        rem_full = nday_reg - 16'd1 - yp;
    end

    always_comb
    begin
        mon_srch = 4'd1;
        for (int i = 2; i <= int'(gthd_pkg::MONTH_LAST); i++)
        begin
            if (gthd_pkg::hijri_month_start(4'(i)) <= rem_reg)
            begin
                mon_srch = 4'(i);
            end
        end
        day_sub  = rem_reg - gthd_pkg::hijri_month_start(mon_srch);
        day_next = day_sub[4:0] + 5'd1;
        mon_next = mon_srch;
        if (mon_srch == 4'(gthd_pkg::MONTH_LAST))
        begin
            mon_next = 4'd12;
            day_next = day_sub[4:0] + 5'd30;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corr_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                corr_reg <= cfg_wdata;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            gy_reg <= s_tdata[11:0];
            gm_reg <= s_tdata[15:12];
            gd_reg <= s_tdata[20:16];
        end
        if (cmd.prep)
        begin
            nday_reg <= nday_next;
        end
        if (cmd.scale)
        begin
            nscl_reg <= 36'(nday_reg) * gthd_pkg::SCALE_E6;
            k_reg    <= 7'd0;
            q_reg    <= 6'd0;
        end
        if (cmd.year_step && year_hit)
        begin
            k_reg <= k_cand;
        end
        if (cmd.frac_step && frac_hit)
        begin
            q_reg <= q_cand;
        end
        if (cmd.rem)
        begin
            rem_reg <= rem_full[8:0];
        end
        if (cmd.month)
        begin
            day_reg  <= day_next;
            mon_reg  <= mon_next;
            year_reg <= 11'(gthd_pkg::HIJRI_EPOCH) + 11'(k_reg);
        end
        if (cmd.out_load)
        begin
            out_data_reg <= {4'd0, year_reg, mon_reg, day_reg};
        end
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = out_data_reg;

endmodule

`default_nettype wire

// ===== sv/gregorian_to_hijri_date.sv =====
// Gregorian to Hijri date converter, tabular lunar calendar.
// Input stream s_*: one word per date, output stream m_*: one word per date.
// Configuration: cfg_wen/cfg_wdata write the signed 3-bit day correction;
// write it only while no date is in flight.
// From input acceptance to m_tvalid a date passes these steps in order:
// day count, scaling, 7-step year search, 6-step fraction search,
// remainder, month search, output load (which waits for a free output).
// One date at a time: s_tready is high only while idle, so a new date is
// taken only after the last one is through its bit-serial searches.
// A finished word sits in the output register; the next date is accepted
// meanwhile, and its result waits in the last step until m_tready frees
// the output register.
// Reset clears the correction to 0, drops m_tvalid and returns to idle.
`default_nettype none

module gregorian_to_hijri_date (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_wdata,    // day_correction
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,      // greg_year[11:0], greg_month[15:12], greg_day[20:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata       // hijri_day[4:0], hijri_month[8:5], hijri_year[19:9]
);

    gthd_pkg::cmd_t    cmd;
    gthd_pkg::status_t status;

    gthd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gthd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// ===== tb/sv/gregorian_to_hijri_date_tb.sv =====
`timescale 1ns / 1ps

module gregorian_to_hijri_date_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_DATES = 190;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [10:0] year;
    } hijri_date_t;

    class hijri_scoreboard;
        hijri_date_t pending_dates[$];
        int          day_shift;
        int          errors;

        function new();
            day_shift = 0;
            errors = 0;
        endfunction

        // day count of hijri (year, month, 1) from the 2000-based epoch
        static function longint lunar_month_first_day(longint year, longint month);
            return (29500 * month - 28999) / 1000
                + (354367068 * (year - 1420)) / 1000000 + 1;
        endfunction

        static function hijri_date_t to_hijri(bit [11:0] gy, bit [3:0] gm, bit [4:0] gd,
                                              int shift);
            longint      y;
            longint      m;
            longint      nday;
            longint      yr;
            longint      mo;
            longint      dy;
            hijri_date_t r;
            y = longint'(gy);
            m = longint'(gm);
            if (y < 2001)
                y = 2001;
            if (y > 2099)
                y = 2099;
            if (m < 1)
                m = 1;
            if (m > 12)
                m = 12;
            if (m < 3)
            begin
                y = y - 1;
                m = m + 12;
            end
            y = y - 2000;
            nday = (36525 * y) / 100 + (306001 * (m + 1)) / 10000 + longint'(gd) + 197
                + longint'(shift);
            yr = (nday * 1000000) / 354367068 + 1420;
            if (yr > 1420)
                yr = yr - 1;
            repeat (4)
            begin
                if (lunar_month_first_day(yr + 1, 1) <= nday)
                    yr = yr + 1;
            end
            mo = 1;
            for (int i = 2; i <= 13; i++)
            begin
                if (lunar_month_first_day(yr, longint'(i)) <= nday)
                    mo = longint'(i);
            end
            dy = 1 + nday - lunar_month_first_day(yr, mo);
            // thirteenth month start folds into the last day of month 12
            if (mo == 13)
            begin
                mo = 12;
                dy = dy + 29;
            end
            r.day = dy[4:0];
            r.month = mo[3:0];
            r.year = yr[10:0];
            return r;
        endfunction

        function void note_date(bit [11:0] gy, bit [3:0] gm, bit [4:0] gd);
            pending_dates.push_back(to_hijri(gy, gm, gd, day_shift));
        endfunction

        function void check_word(logic [23:0] word);
            hijri_date_t want;
            if (pending_dates.size() == 0)
            begin
                $error("unexpected result word %h", word);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            if (word[4:0] !== want.day)
            begin
                $error("hijri_day: expected %0d, got %0d", want.day, word[4:0]);
                errors++;
            end
            if (word[8:5] !== want.month)
            begin
                $error("hijri_month: expected %0d, got %0d", want.month, word[8:5]);
                errors++;
            end
            if (word[19:9] !== want.year)
            begin
                $error("hijri_year: expected %0d, got %0d", want.year, word[19:9]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wen;
    logic [2:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    hijri_scoreboard sb;
    bit  tx_gaps;
    bit  rx_gaps;
    bit  rx_running;
    int  rx_hold_left;
    int  cycle_count;

    gregorian_to_hijri_date dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // result side: random stalls plus an optional long hold-off
    always @(negedge clk)
    begin
        if (!rx_running)
            m_tready <= 1'b0;
        else if (rx_hold_left > 0)
        begin
            m_tready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else
            m_tready <= !(rx_gaps && $urandom_range(0, 99) < 24);
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_date(bit [11:0] gy, bit [3:0] gm, bit [4:0] gd);
        while (tx_gaps && $urandom_range(0, 99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, gd, gm, gy};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_date(gy, gm, gd);
        @(negedge clk);
    endtask

    task automatic send_random_date();
        bit [11:0] gy;
        bit [3:0]  gm;
        bit [4:0]  gd;
        int        last_day;
        if ($urandom_range(0, 99) < 85)
        begin
            gy = 12'($urandom_range(2001, 2099));
            gm = 4'($urandom_range(1, 12));
            if (gm == 2)
                last_day = (gy % 4 == 0) ? 29 : 28;
            else if (gm == 4 || gm == 6 || gm == 9 || gm == 11)
                last_day = 30;
            else
                last_day = 31;
            gd = 5'($urandom_range(1, last_day));
        end
        else
        begin
            gy = 12'($urandom_range(0, 4095));
            gm = 4'($urandom_range(0, 15));
            gd = 5'($urandom_range(0, 31));
        end
        send_date(gy, gm, gd);
    endtask

    task automatic set_correction(logic signed [2:0] shift);
        s_tvalid <= 1'b0;
        while (sb.pending_dates.size() != 0)
            @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= shift;
        @(negedge clk);
        cfg_wen <= 1'b0;
        sb.day_shift = int'(shift);
    endtask

    initial
    begin
        int          shifts[8];
        hijri_date_t probe;
        int          folds;
        bit [11:0]   fold_y[2];
        bit [3:0]    fold_m[2];
        bit [4:0]    fold_d[2];

        shifts = '{-4, 3, -1, 1, 2, -2, -3, 0};
        rst_n <= 1'b0;
        cfg_wen <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        rx_running = 1'b0;
        rx_hold_left = 0;
        cycle_count = 0;
        sb = new();

        // dates landing on the folded thirteenth month start
        folds = 0;
        for (int y = 2001; y <= 2099 && folds < 2; y++)
            for (int m = 1; m <= 12 && folds < 2; m++)
                for (int d = 1; d <= 28 && folds < 2; d++)
                begin
                    probe = hijri_scoreboard::to_hijri(12'(y), 4'(m), 5'(d), 0);
                    if (probe.month == 12 && probe.day == 30)
                    begin
                        fold_y[folds] = 12'(y);
                        fold_m[folds] = 4'(m);
                        fold_d[folds] = 5'(d);
                        folds++;
                    end
                end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        rx_running = 1'b1;

        // directed dates at reset correction
        send_date(2001, 1, 1);
        send_date(2001, 2, 28);
        send_date(2001, 3, 1);
        send_date(2099, 12, 31);
        send_date(2099, 1, 1);
        send_date(2000, 6, 15);
        send_date(0, 0, 0);
        send_date(4095, 15, 31);
        send_date(2024, 2, 29);
        send_date(2050, 2, 29);
        send_date(2003, 2, 31);
        send_date(2001, 3, 0);
        send_date(2030, 13, 5);
        send_date(2030, 0, 10);
        send_date(2045, 7, 31);
        send_date(2012, 11, 30);
        send_date(2077, 8, 16);
        send_date(2100, 1, 1);
        for (int i = 0; i < folds; i++)
            send_date(fold_y[i], fold_m[i], fold_d[i]);

        for (int p = 0; p < 8; p++)
        begin
            set_correction(shifts[p][2:0]);
            tx_gaps = (p != 2);
            rx_gaps = (p != 2);
            if (p == 4)
                rx_hold_left = 400;
            if (p == 0)
            begin
                send_date(2001, 1, 1);
                send_date(2099, 12, 31);
            end
            if (p == 1)
            begin
                send_date(2001, 1, 1);
                send_date(2099, 12, 31);
            end
            repeat (PHASE_DATES)
                send_random_date();
        end
        s_tvalid <= 1'b0;

        while (sb.pending_dates.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
